// ----- design/wfd_pkg.sv -----
// Package for the WebSocket frame deframer: phase and event codes, constants and shared structs.
`timescale 1ns / 1ps

package wfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        EV_HEADER,
        EV_TEXT,
        EV_OTHER,
        EV_CLOSE,
        EV_FRAG,
        EV_BIG,
        EV_HALT
    } t_event;

    localparam logic [3:0]  OPC_TEXT      = 4'h1;
    localparam logic [3:0]  OPC_CLOSE     = 4'h8;
    localparam logic [6:0]  LEN_CODE_16   = 7'd126;
    localparam logic [6:0]  LEN_CODE_64   = 7'd127;
    localparam logic [2:0]  EXT16_LAST    = 3'd1;
    localparam logic [2:0]  EXT64_LAST    = 3'd7;
    localparam logic [2:0]  MASK_LAST     = 3'd3;
    localparam logic [31:0] MAX_LEN_RESET = 32'd10485760;

    typedef struct packed {
        t_event     ev;
        logic [7:0] data;
        logic       done;
        logic [3:0] opcode;
    } t_result;

    typedef struct packed {
        logic stopped;
        logic in_payload;
        logic remain_zero;
    } t_status;

endpackage

// ----- design/wfd_in_stage.sv -----
// Input register for received bytes with stall back to the sender.
`timescale 1ns / 1ps

module wfd_in_stage import wfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       load;

    assign o_in_stall = r_valid && !i_take;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- design/wfd_parser.sv -----
// Frame parser: header phases, length check, unmasking and stop handling for one byte per cycle while not stalled.
`timescale 1ns / 1ps

module wfd_parser import wfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_max_len,
    output t_result     o_result,
    output t_status     o_status
);

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_opc,    n_opc;
    logic        r_fin,    n_fin;
    logic        r_mask,   n_mask;
    logic [63:0] r_len,    n_len;
    logic [2:0]  r_hbc,    n_hbc;
    logic [31:0] r_key,    n_key;
    logic [1:0]  r_idx,    n_idx;
    logic [31:0] r_remain, n_remain;
    logic        r_stopped, n_stopped;

    t_event      ev;
    logic [7:0]  data;
    logic        done;
    logic        hdr_end;
    logic [7:0]  key_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR1;
            r_opc     <= '0;
            r_fin     <= 1'b0;
            r_mask    <= 1'b0;
            r_len     <= '0;
            r_hbc     <= '0;
            r_key     <= '0;
            r_idx     <= '0;
            r_remain  <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_opc     <= n_opc;
            r_fin     <= n_fin;
            r_mask    <= n_mask;
            r_len     <= n_len;
            r_hbc     <= n_hbc;
            r_key     <= n_key;
            r_idx     <= n_idx;
            r_remain  <= n_remain;
            r_stopped <= n_stopped;
        end
    end

    // First key byte received sits in the top byte of the key register
    always_comb begin
        case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_opc     = r_opc;
        n_fin     = r_fin;
        n_mask    = r_mask;
        n_len     = r_len;
        n_hbc     = r_hbc;
        n_key     = r_key;
        n_idx     = r_idx;
        n_remain  = r_remain;
        n_stopped = r_stopped;
        ev        = EV_HEADER;
        data      = 8'd0;
        done      = 1'b0;
        hdr_end   = 1'b0;

        if (i_fire) begin
            if (r_stopped) begin
                ev = EV_HALT;
            end else begin
                unique case (r_phase)
                    PH_HDR1: begin
                        n_fin   = i_byte[7];
                        n_opc   = i_byte[3:0];
                        n_key   = '0;
                        n_len   = '0;
                        n_idx   = '0;
                        n_hbc   = '0;
                        n_phase = PH_HDR2;
                    end
                    PH_HDR2: begin
                        n_mask = i_byte[7];
                        if (!r_fin) begin
                            n_stopped = 1'b1;
                            ev        = EV_FRAG;
                        end else begin
                            n_hbc = '0;
                            if (i_byte[6:0] == LEN_CODE_16) begin
                                n_len   = '0;
                                n_phase = PH_EXT16;
                            end else if (i_byte[6:0] == LEN_CODE_64) begin
                                n_len   = '0;
                                n_phase = PH_EXT64;
                            end else begin
                                n_len = {57'd0, i_byte[6:0]};
                                if (i_byte[7]) begin
                                    n_phase = PH_MASK;
                                end else begin
                                    hdr_end = 1'b1;
                                end
                            end
                        end
                    end
                    PH_EXT16, PH_EXT64: begin
                        n_len = {r_len[55:0], i_byte};
                        n_hbc = r_hbc + 3'd1;
                        if (r_hbc == ((r_phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
                            n_hbc = '0;
                            if (r_mask) begin
                                n_phase = PH_MASK;
                            end else begin
                                hdr_end = 1'b1;
                            end
                        end
                    end
                    PH_MASK: begin
                        n_key = {r_key[23:0], i_byte};
                        n_hbc = r_hbc + 3'd1;
                        if (r_hbc == MASK_LAST) begin
                            n_hbc   = '0;
                            hdr_end = 1'b1;
                        end
                    end
                    PH_PAYLOAD: begin
                        data  = i_byte ^ (r_mask ? key_byte : 8'd0);
                        ev    = (r_opc == OPC_TEXT) ? EV_TEXT : EV_OTHER;
                        n_idx = r_idx + 2'd1;
                        if (r_remain == 32'd1) begin
                            done    = 1'b1;
                            n_phase = PH_HDR1;
                            if (r_opc == OPC_CLOSE) begin
                                n_stopped = 1'b1;
                                ev        = EV_CLOSE;
                            end
                        end else begin
                            n_remain = r_remain - 32'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_HDR1;
                    end
                endcase

                // Header finished: check the length, then go to payload or end the frame
                if (hdr_end) begin
                    if ((n_len[63:32] != 32'd0) || (n_len[31:0] > i_max_len)) begin
                        n_stopped = 1'b1;
                        ev        = EV_BIG;
                    end else if (n_len == 64'd0) begin
                        done    = 1'b1;
                        n_phase = PH_HDR1;
                        if (r_opc == OPC_CLOSE) begin
                            n_stopped = 1'b1;
                            ev        = EV_CLOSE;
                        end
                    end else begin
                        n_remain = n_len[31:0];
                        n_idx    = '0;
                        n_phase  = PH_PAYLOAD;
                    end
                end
            end
        end

        o_result.ev     = ev;
        o_result.data   = data;
        o_result.done   = done;
        o_result.opcode = n_opc;
    end

    assign o_status.stopped     = r_stopped;
    assign o_status.in_payload  = (r_phase == PH_PAYLOAD);
    assign o_status.remain_zero = (r_remain == 32'd0);

endmodule

// ----- design/wfd_out_stage.sv -----
// Result register holding one parsed result until the receiver takes it.
`timescale 1ns / 1ps

module wfd_out_stage import wfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_take,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Advance whenever the register is empty or being drained
    assign o_take = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

// ----- design/websocket_frame_deframer_core.sv -----
// Top level of the WebSocket frame deframer: input stage, parser, result stage, config register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_rx_byte
//  out     | output    | o_out_valid/i_out_stall | o_event_res, o_data_byte, o_frame_done,
//          |           |                         | o_frame_opcode
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (max_payload_len)
//
// One byte per cycle sustained while the output is not stalled; an accepted request passes
// through the input register, then the parser logic, into the result register.
// Reset (synchronous, active low) returns the parser to the first header byte, clears the
// stop flag and loads max_payload_len with 10485760.
// A stalled result holds; the input register keeps taking bytes until it is full as well.
// Config writes are always ready and take effect on the next parsed byte.
`timescale 1ns / 1ps

module websocket_frame_deframer_core import wfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_done,
    output logic [3:0]  o_frame_opcode,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_max_len;
    logic        take;
    logic        stg_valid;
    logic [7:0]  stg_byte;
    t_result     parse_res;
    t_result     out_res;
    t_status     status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    wfd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_take     (take),
        .o_valid    (stg_valid),
        .o_byte     (stg_byte)
    );

    wfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (stg_valid && take),
        .i_byte    (stg_byte),
        .i_max_len (r_max_len),
        .o_result  (parse_res),
        .o_status  (status)
    );

    wfd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid),
        .i_result    (parse_res),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_res)
    );

    assign o_event_res    = out_res.ev;
    assign o_data_byte    = out_res.data;
    assign o_frame_done   = out_res.done;
    assign o_frame_opcode = out_res.opcode;

    // A stop event on the output means the parser has already latched its stop flag
    a_stop_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (out_res.ev == EV_FRAG || out_res.ev == EV_BIG
                        || out_res.ev == EV_CLOSE) |-> status.stopped)
        else $error("stop event delivered without stop flag");

    // Only payload events carry data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (out_res.ev == EV_HEADER || out_res.ev == EV_FRAG
                        || out_res.ev == EV_BIG || out_res.ev == EV_HALT)
        |-> out_res.data == 8'd0)
        else $error("data byte set on a non-payload event");

    // Errors and halted bytes never complete a frame
    a_done_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && out_res.done
        |-> out_res.ev != EV_FRAG && out_res.ev != EV_BIG && out_res.ev != EV_HALT)
        else $error("frame done on an error or halted event");

    // The payload phase always has bytes left to read
    a_remain_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.in_payload |-> !status.remain_zero)
        else $error("payload phase with zero bytes remaining");

endmodule
